@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk, skipped while reset is asserted.
`define SST_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sst assertion failed");

// Checked at every rising clk, reset included.
`define SST_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("sst assertion failed");

`endif

@@ hw/rtl/sst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Types, constants and character classes for the source text tokenizer.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int POS_W = 16;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam int F_NUM = 0;
	localparam int F_DOT = 1;
	localparam int F_ID  = 2;
	localparam int F_OP  = 3;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_BAD_OP = 3'd1,
		ERR_CHAR   = 3'd2,
		ERR_DOT2   = 3'd3,
		ERR_LETTER = 3'd4
	} err_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] start;
		logic [15:0] length;
		err_t        err;
		logic        last;
	} res_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SP || c == CH_CR || c == CH_TAB || c == CH_LF;
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return is_space(c) || c == "." || c == "," || c == ":" || c == ";" ||
			c == "(" || c == ")" || c == "[" || c == "]" || c == "{" ||
			c == "}" || c == "\"" || c == "'";
	endfunction

	function automatic logic is_op_char(input logic [7:0] c);
		return c == "=" || c == "!" || c == "<" || c == ">" || c == "?" ||
			c == "/" || c == "*" || c == "+" || c == "-" || c == "^" ||
			c == "%" || c == "&" || c == "|";
	endfunction

	function automatic logic op_span_ok(input logic [1:0] cnt, input logic [15:0] opc);
		logic [7:0] a;
		logic [7:0] b;
		logic       ok;
		a  = opc[7:0];
		b  = opc[15:8];
		ok = 1'b0;
		if (cnt == 2'd1) begin
			ok = a == "=" || a == ">" || a == "<" || a == "*" || a == "/" ||
				a == "+" || a == "-" || a == "^" || a == "%" || a == "!" ||
				a == "?";
		end else if (cnt == 2'd2) begin
			if (b == "=") begin
				ok = a == "/" || a == "*" || a == "-" || a == "+" ||
					a == "=" || a == "!" || a == ">" || a == "<";
			end else begin
				ok = (a == "&" && b == "&") || (a == "|" && b == "|");
			end
		end
		return ok;
	endfunction

	function automatic logic [15:0] sat16(input logic [POS_W-1:0] x);
		logic [31:0] w;
		w = 32'(x);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

endpackage

@@ hw/rtl/source_text_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Splits a character stream into token spans with error codes.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | char_code, end_of_text
//  output   | out_valid / out_stall| token_valid, span_begin, span_size,
//           |                      | error_code, last_result
//
// One character is classified and the state updated in the cycle it is taken.
// Its 0 to 2 results enter a 4-entry result queue and leave one per cycle if
// not stalled, so the rate is one character per cycle with at most one result.
// in_stall is high while the queue has fewer than two free entries.
// Reset clears position, span, class and queue; queue payload is not reset.
module source_text_tokenizer import sst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        token_valid,
	output logic [15:0] span_begin,
	output logic [15:0] span_size,
	output logic [2:0]  error_code,
	output logic        last_result
);

	logic [POS_W-1:0] pos_q, start_q, end_q;
	logic [3:0]       flags_q;
	logic [15:0]      opc_q;
	logic [1:0]       cnt_q;

	logic [POS_W-1:0] pos_n, start_n, end_n, nx, span_len;
	logic [3:0]       flags_n;
	logic [15:0]      opc_n, opc_b;
	logic [1:0]       cnt_n, cnt_b;
	logic             cap, flush_en, sec_en;
	logic             ci, cn, co;
	err_t             cerr;
	res_t             flush_res, sec_res, ent_a, ent_b;

	res_t             fifo_q [4];
	logic [1:0]       wr_q, rd_q;
	logic [2:0]       count_q;
	logic [1:0]       n_push;
	logic             acc_in, pop;

	assign nx       = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign span_len = end_q - start_q;

	always_comb begin
		pos_n    = pos_q;
		start_n  = start_q;
		end_n    = end_q;
		flags_n  = flags_q;
		cnt_b    = cnt_q;
		opc_b    = opc_q;
		cap      = 1'b0;
		flush_en = 1'b0;
		sec_en   = 1'b0;
		ci       = (char_code >= "A" && char_code <= "Z") ||
			(char_code >= "a" && char_code <= "z") || char_code == "_";
		cn       = char_code >= "0" && char_code <= "9";
		co       = !ci && !cn && is_op_char(char_code);
		cerr     = ERR_NONE;
		sec_res  = '{valid: 1'b0, start: 16'h0, length: 16'h0, err: ERR_NONE, last: 1'b1};

		if (end_of_text) begin
			flush_en = span_len != '0;
			pos_n    = '0;
			start_n  = '0;
			end_n    = '0;
			flags_n  = '0;
			cnt_b    = '0;
			opc_b    = '0;
		end else if (is_punct(char_code)) begin
			if (char_code == "." && flags_q[F_NUM]) begin
				sec_en         = flags_q[F_DOT];
				sec_res.err    = ERR_DOT2;
				flags_n[F_DOT] = 1'b1;
				end_n          = nx;
				cap            = 1'b1;
			end else begin
				flush_en = span_len != '0;
				flags_n  = '0;
				if (!is_space(char_code)) begin
					sec_en         = 1'b1;
					sec_res.valid  = 1'b1;
					sec_res.start  = sat16(pos_q);
					sec_res.length = 16'd1;
				end
				start_n = nx;
				end_n   = nx;
				cnt_b   = '0;
				opc_b   = '0;
			end
			pos_n = nx;
		end else begin
			if (!ci && !cn && !co) cerr = ERR_CHAR;
			if (!flags_q[F_NUM] && !flags_q[F_ID] && !flags_q[F_OP]) begin
				flags_n[F_ID]  = ci;
				flags_n[F_NUM] = cn;
				flags_n[F_OP]  = co;
			end else if (ci && flags_q[F_NUM]) begin
				if (flags_q[F_DOT]) cerr = ERR_LETTER;
				flags_n[F_NUM] = 1'b0;
				flags_n[F_ID]  = 1'b1;
			end else if ((ci || cn) && flags_q[F_OP]) begin
				flush_en = span_len != '0;
				flags_n  = '0;
				flags_n[F_ID]  = ci;
				flags_n[F_NUM] = !ci;
				start_n  = pos_q;
				cnt_b    = '0;
				opc_b    = '0;
			end else if ((flags_q[F_ID] || flags_q[F_NUM]) && co) begin
				flush_en = span_len != '0;
				flags_n  = '0;
				flags_n[F_OP] = 1'b1;
				start_n  = pos_q;
				cnt_b    = '0;
				opc_b    = '0;
			end
			end_n       = nx;
			cap         = 1'b1;
			sec_en      = cerr != ERR_NONE;
			sec_res.err = cerr;
			pos_n       = nx;
		end

		opc_n = opc_b;
		cnt_n = cnt_b;
		if (cap) begin
			if (cnt_b == 2'd0) begin
				opc_n = {8'h00, char_code};
			end else if (cnt_b == 2'd1) begin
				opc_n = {char_code, opc_b[7:0]};
			end
			cnt_n = (cnt_b == 2'd3) ? cnt_b : cnt_b + 2'd1;
		end

		flush_res.valid  = 1'b1;
		flush_res.start  = sat16(start_q);
		flush_res.length = sat16(span_len);
		flush_res.err    = (flags_q[F_OP] && !op_span_ok(cnt_q, opc_q)) ? ERR_BAD_OP : ERR_NONE;
		flush_res.last   = !sec_en;

		ent_a  = flush_en ? flush_res : sec_res;
		ent_b  = sec_res;
		n_push = {1'b0, flush_en} + {1'b0, sec_en};
	end

	assign in_stall  = count_q > 3'd2;
	assign acc_in    = in_valid && !in_stall;
	assign out_valid = count_q != 3'd0;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			end_q   <= '0;
			flags_q <= '0;
			opc_q   <= '0;
			cnt_q   <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (acc_in) begin
				pos_q   <= pos_n;
				start_q <= start_n;
				end_q   <= end_n;
				flags_q <= flags_n;
				opc_q   <= opc_n;
				cnt_q   <= cnt_n;
				wr_q    <= wr_q + n_push;
			end
			if (pop) rd_q <= rd_q + 2'd1;
			count_q <= count_q + (acc_in ? 3'(n_push) : 3'd0) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			if (n_push != 2'd0) fifo_q[wr_q] <= ent_a;
			if (n_push == 2'd2) fifo_q[wr_q + 2'd1] <= ent_b;
		end
	end

	assign token_valid = fifo_q[rd_q].valid;
	assign span_begin  = fifo_q[rd_q].start;
	assign span_size   = fifo_q[rd_q].length;
	assign error_code  = fifo_q[rd_q].err;
	assign last_result = fifo_q[rd_q].last;

endmodule

@@ hw/rtl/sst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sst_checker import sst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        token_valid,
	input logic [15:0] span_begin,
	input logic [15:0] span_size,
	input logic [2:0]  error_code,
	input logic        last_result
);

	`SST_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(span_begin) &&
		$stable(span_size) && $stable(error_code) && $stable(last_result))
	`SST_ASSERT(a_empty_span, out_valid && !token_valid |-> span_begin == 16'd0 && span_size == 16'd0)
	`SST_ASSERT(a_bare_err, out_valid && !token_valid |-> error_code != 3'(ERR_NONE))
	`SST_ASSERT(a_token_err, out_valid && token_valid |-> error_code == 3'(ERR_NONE) || error_code == 3'(ERR_BAD_OP))
	`SST_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid)

endmodule

bind source_text_tokenizer sst_checker u_sst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.token_valid  (token_valid),
	.span_begin   (span_begin),
	.span_size    (span_size),
	.error_code   (error_code),
	.last_result  (last_result)
);
